// ===== rtl/core/crfd_pkg.sv =====
`timescale 1ns / 1ps

package crfd_pkg;

    localparam int unsigned FRAME_BYTES = 14;
    localparam int unsigned FILL_W      = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned UID_W       = 32;
    localparam int unsigned CFG_INDEX_W = 4;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h20;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h03;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic             found;
        logic [UID_W-1:0] card_uid;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_push_t;

endpackage

// ===== rtl/core/card_reply_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// Reply frame deframer. Takes one received byte per cycle while not stalled
// and scans the last 14 bytes of the current batch for a frame that opens
// with the start marker, closes with the end marker and carries in byte 12
// the inverted XOR of bytes 1 to 11. The first such frame in a batch gives
// one word with found set and the UID from bytes 8 to 11; a batch that ends
// without one gives one word with found clear and a zero UID. The checksum
// compare is combinational on the window register and the incoming byte,
// ahead of a two-word output buffer that registers each result, and input
// stalls only while both buffer words are held by a stalled output.
// Registers: index 0 is the start marker (reset 0x20), index 1 the end marker
// (reset 0x03); other indexes are ignored, and writes are always ready.

module card_reply_frame_deframer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    input  logic                                batch_first,
    input  logic                                batch_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [31:0]                         card_uid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam logic [crfd_pkg::CFG_INDEX_W-1:0] REG_START_MARKER =
        crfd_pkg::CFG_INDEX_W'(0);
    localparam logic [crfd_pkg::CFG_INDEX_W-1:0] REG_END_MARKER   =
        crfd_pkg::CFG_INDEX_W'(1);

    crfd_pkg::byte_t        start_marker_reg;
    crfd_pkg::byte_t        end_marker_reg;
    crfd_pkg::result_push_t push;
    crfd_pkg::result_t      out_data;
    logic                   in_accept;
    logic                   buf_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;
    assign found     = out_data.found;
    assign card_uid  = out_data.card_uid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= crfd_pkg::START_MARKER_RESET;
            end_marker_reg   <= crfd_pkg::END_MARKER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    crfd_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .rx_byte      (rx_byte),
        .batch_first  (batch_first),
        .batch_last   (batch_last),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .push         (push)
    );

    crfd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // The buffer fills its second word only behind a held first word.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("input stalled with no result held");

    // A held result word stays unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(card_uid)))
        else $error("held result changed before it was taken");

    // A batch without a frame reports a zero UID.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (card_uid == 32'd0))
        else $error("nonzero UID on a not-found result");
`endif

endmodule

// ===== rtl/core/crfd_window.sv =====
`timescale 1ns / 1ps

module crfd_window
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  crfd_pkg::byte_t       rx_byte,
    input  logic                  batch_first,
    input  logic                  batch_last,
    input  crfd_pkg::byte_t       start_marker,
    input  crfd_pkg::byte_t       end_marker,
    output crfd_pkg::result_push_t push
);

    localparam int unsigned LAST_POS = crfd_pkg::FRAME_BYTES - 1;
    localparam logic [crfd_pkg::FILL_W-1:0] FILL_FULL =
        crfd_pkg::FILL_W'(crfd_pkg::FRAME_BYTES);

    crfd_pkg::byte_t               window_reg [crfd_pkg::FRAME_BYTES];
    logic [crfd_pkg::FILL_W-1:0]   fill_reg;
    logic [crfd_pkg::FILL_W-1:0]   fill_next;
    logic                          done_reg;
    logic                          done_next;
    logic [crfd_pkg::FILL_W-1:0]   fill_base;
    logic [crfd_pkg::FILL_W-1:0]   fill_inc;
    logic                          done_base;
    logic                          frame_ok;
    logic                          hit;
    crfd_pkg::byte_t               check_sum;

    // The frame is checked on the window as it will stand after this word
    // is shifted in, so every position reads one place further along.
    always_comb
    begin
        check_sum = '0;
        for (int i = 2; i <= 12; i++)
        begin
            check_sum = check_sum ^ window_reg[i];
        end
    end

    always_comb
    begin
        fill_base = batch_first ? '0 : fill_reg;
        done_base = batch_first ? 1'b0 : done_reg;
        fill_inc  = (fill_base < FILL_FULL) ? fill_base + 1'b1 : fill_base;
        frame_ok  = (fill_inc == FILL_FULL)
                    && (window_reg[1] == start_marker)
                    && (rx_byte == end_marker)
                    && (~check_sum == window_reg[LAST_POS]);
        hit       = !done_base && frame_ok;

        push.valid = accept && (hit || (batch_last && !done_base));
        push.data.found = hit;
        push.data.card_uid = hit ? {window_reg[9], window_reg[10],
                                    window_reg[11], window_reg[12]} : '0;

        if (batch_last)
        begin
            fill_next = '0;
            done_next = 1'b0;
        end
        else
        begin
            fill_next = fill_inc;
            done_next = done_base || hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LAST_POS; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[LAST_POS] <= rx_byte;
        end
    end

endmodule

// ===== rtl/core/crfd_out_buf.sv =====
`timescale 1ns / 1ps

module crfd_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  crfd_pkg::result_push_t push,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output crfd_pkg::result_t      out_data
);

    logic              main_valid_reg;
    crfd_pkg::result_t main_data_reg;
    logic              skid_valid_reg;
    crfd_pkg::result_t skid_data_reg;
    logic              take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!main_valid_reg || take)
        begin
            main_valid_reg <= push.valid;
        end
        else if (push.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (!main_valid_reg || take)
        begin
            main_data_reg <= push.data;
        end
        else if (push.valid)
        begin
            skid_data_reg <= push.data;
        end
    end

endmodule

// ===== dv/crfd_tb_pkg.sv =====
`timescale 1ns / 1ps

package crfd_tb_pkg;

    typedef enum logic [crfd_pkg::CFG_INDEX_W-1:0] {
        REG_START_MARKER = 0,
        REG_END_MARKER   = 1,
        REG_FIRST_UNUSED = 2
    } crfd_reg_t;

endpackage

// ===== dv/crfd_frame_checker.sv =====
`timescale 1ns / 1ps

module crfd_frame_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    input  logic                             batch_first,
    input  logic                             batch_last,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             found,
    input  logic [31:0]                      card_uid,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [crfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output int                               mismatches,
    output int                               pending,
    output int                               frames_found,
    output int                               batches_missed
);

    localparam int REPORT_LIMIT = 10;
    localparam int CHECK_FIRST  = 1;
    localparam int CHECK_LAST   = 11;
    localparam int CHECK_AT     = 12;
    localparam int UID_AT       = 8;

    crfd_pkg::byte_t             window [crfd_pkg::FRAME_BYTES];
    logic [crfd_pkg::FILL_W-1:0] fill;
    logic                        reported;
    crfd_pkg::byte_t             start_mark;
    crfd_pkg::byte_t             end_mark;
    crfd_pkg::result_t           expected_uids [$];
    int                          errs;
    int                          hits;
    int                          misses;

    // Shifts one byte into the window and tells whether it closes a batch
    // or completes the first good frame of the batch.
    function automatic logic scan_byte(input crfd_pkg::byte_t b, input logic first,
                                       input logic last, output crfd_pkg::result_t res);
        crfd_pkg::byte_t sum;
        logic            emit;
        int              i;
        emit = 1'b0;
        res = '0;
        if (first)
        begin
            for (i = 0; i < crfd_pkg::FRAME_BYTES; i++)
                window[i] = '0;
            fill = '0;
            reported = 1'b0;
        end
        for (i = 0; i < crfd_pkg::FRAME_BYTES - 1; i++)
            window[i] = window[i + 1];
        window[crfd_pkg::FRAME_BYTES - 1] = b;
        if (fill < crfd_pkg::FRAME_BYTES)
            fill = fill + 1'b1;
        if (!reported && fill == crfd_pkg::FRAME_BYTES && window[0] == start_mark &&
            window[crfd_pkg::FRAME_BYTES - 1] == end_mark)
        begin
            sum = '0;
            for (i = CHECK_FIRST; i <= CHECK_LAST; i++)
                sum ^= window[i];
            sum = ~sum;
            if (sum == window[CHECK_AT])
            begin
                emit = 1'b1;
                res.found = 1'b1;
                res.card_uid = {window[UID_AT], window[UID_AT + 1],
                                window[UID_AT + 2], window[UID_AT + 3]};
                reported = 1'b1;
            end
        end
        if (last)
        begin
            if (!reported)
            begin
                emit = 1'b1;
                res = '0;
            end
            fill = '0;
            reported = 1'b0;
        end
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        crfd_pkg::result_t want;
        int                i;
        if (!rst_n)
        begin
            for (i = 0; i < crfd_pkg::FRAME_BYTES; i++)
                window[i] = '0;
            fill = '0;
            reported = 1'b0;
            start_mark = crfd_pkg::START_MARKER_RESET;
            end_mark = crfd_pkg::END_MARKER_RESET;
            expected_uids.delete();
            errs = 0;
            hits = 0;
            misses = 0;
            mismatches <= 0;
            pending <= 0;
            frames_found <= 0;
            batches_missed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crfd_tb_pkg::REG_START_MARKER: start_mark = cfg_data;
                    crfd_tb_pkg::REG_END_MARKER:   end_mark = cfg_data;
                    default:                       ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (scan_byte(rx_byte, batch_first, batch_last, want))
                    expected_uids = {expected_uids, want};
            end
            if (out_valid && !out_stall)
            begin
                if (expected_uids.size() == 0)
                begin
                    if (errs < REPORT_LIMIT)
                        $display("Unexpected result word: found=%0b card_uid=%08h",
                                 found, card_uid);
                    errs++;
                end
                else
                begin
                    want = expected_uids.pop_front();
                    if (found !== want.found || card_uid !== want.card_uid)
                    begin
                        if (errs < REPORT_LIMIT)
                            $display("Mismatch: want found=%0b uid=%08h, got found=%0b uid=%08h",
                                     want.found, want.card_uid, found, card_uid);
                        errs++;
                    end
                    if (want.found)
                        hits++;
                    else
                        misses++;
                end
            end
            mismatches <= errs;
            pending <= expected_uids.size();
            frames_found <= hits;
            batches_missed <= misses;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 320;
    localparam int HOLD_PHASE    = 1;
    localparam int DRAIN_PHASE   = 2;
    localparam int QUIET_PHASE   = 4;
    localparam int UID_AT        = 8;
    localparam int CHECK_AT      = 12;

    typedef enum int { FLAW_NONE, FLAW_CHECK, FLAW_START, FLAW_END } frame_flaw_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    crfd_pkg::byte_t                  rx_byte = '0;
    logic                             batch_first = 1'b0;
    logic                             batch_last = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             found;
    logic [31:0]                      card_uid;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [crfd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    crfd_pkg::byte_t                  cfg_data = '0;

    logic            quiet = 1'b0;
    int              hold_reqs = 0;
    int              words_sent = 0;
    crfd_pkg::byte_t cur_start = crfd_pkg::START_MARKER_RESET;
    crfd_pkg::byte_t cur_end = crfd_pkg::END_MARKER_RESET;
    int              mismatches;
    int              pending;
    int              frames_found;
    int              batches_missed;

    card_reply_frame_deframer_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .batch_first (batch_first),
        .batch_last  (batch_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .card_uid    (card_uid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    crfd_frame_checker frame_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .batch_first    (batch_first),
        .batch_last     (batch_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .card_uid       (card_uid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .frames_found   (frames_found),
        .batches_missed (batches_missed)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic send_word(input crfd_pkg::byte_t b, input logic first, input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        batch_first <= first;
        batch_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_run(input int n, input logic first, input logic last);
        int i;
        for (i = 0; i < n; i++)
            send_word(crfd_pkg::byte_t'($urandom_range(255)), first && i == 0,
                      last && i == n - 1);
    endtask

    task automatic send_frame(input crfd_pkg::byte_t sm, input crfd_pkg::byte_t em,
                              input logic [31:0] uid, input frame_flaw_t flaw,
                              input logic first, input logic last);
        crfd_pkg::byte_t f [crfd_pkg::FRAME_BYTES];
        crfd_pkg::byte_t sum;
        int              i;
        f[0] = sm;
        for (i = 1; i < UID_AT; i++)
            f[i] = crfd_pkg::byte_t'($urandom_range(255));
        {f[UID_AT], f[UID_AT + 1], f[UID_AT + 2], f[UID_AT + 3]} = uid;
        sum = '0;
        for (i = 1; i < CHECK_AT; i++)
            sum ^= f[i];
        f[CHECK_AT] = ~sum;
        f[crfd_pkg::FRAME_BYTES - 1] = em;
        case (flaw)
            FLAW_CHECK: f[CHECK_AT] ^= crfd_pkg::byte_t'(1 << $urandom_range(7));
            FLAW_START: f[0] ^= crfd_pkg::byte_t'($urandom_range(1, 255));
            FLAW_END:   f[crfd_pkg::FRAME_BYTES - 1] ^= crfd_pkg::byte_t'($urandom_range(1, 255));
            default:    ;
        endcase
        for (i = 0; i < crfd_pkg::FRAME_BYTES; i++)
            send_word(f[i], first && i == 0, last && i == crfd_pkg::FRAME_BYTES - 1);
    endtask

    function automatic logic [31:0] pick_uid();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly batches built around a well-formed frame, with flawed frames,
    // short batches and flag noise mixed in.
    task automatic run_batches(input int budget);
        int   stop_at;
        int   kind;
        int   pre;
        int   post;
        int   n;
        int   i;
        logic first;
        logic twin;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            kind = $urandom_range(99);
            first = ($urandom_range(99) < 80);
            if (kind < 55)
            begin
                pre = $urandom_range(0, 6);
                post = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 4);
                twin = ($urandom_range(3) == 0);
                send_run(pre, first, 1'b0);
                send_frame(cur_start, cur_end, pick_uid(), FLAW_NONE, first && pre == 0,
                           !twin && post == 0);
                if (twin)
                    send_frame(cur_start, cur_end, pick_uid(), FLAW_NONE, 1'b0, post == 0);
                send_run(post, 1'b0, 1'b1);
            end
            else if (kind < 70)
            begin
                pre = $urandom_range(0, 3);
                send_run(pre, first, 1'b0);
                send_frame(cur_start, cur_end, pick_uid(),
                           frame_flaw_t'($urandom_range(FLAW_CHECK, FLAW_END)),
                           first && pre == 0, 1'b1);
            end
            else if (kind < 85)
            begin
                send_run($urandom_range(1, crfd_pkg::FRAME_BYTES - 1), first, 1'b1);
            end
            else
            begin
                n = $urandom_range(1, 30);
                for (i = 0; i < n; i++)
                    send_word(crfd_pkg::byte_t'($urandom_range(255)), $urandom_range(9) == 0,
                              $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_markers(input crfd_pkg::byte_t sm, input crfd_pkg::byte_t em);
        cfg_valid <= 1'b1;
        cfg_index <= crfd_tb_pkg::REG_START_MARKER;
        cfg_data <= sm;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= crfd_tb_pkg::REG_END_MARKER;
        cfg_data <= em;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= crfd_pkg::CFG_INDEX_W'($urandom_range(crfd_tb_pkg::REG_FIRST_UNUSED,
                                                           (1 << crfd_pkg::CFG_INDEX_W) - 1));
        cfg_data <= crfd_pkg::byte_t'($urandom_range(255));
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_start = sm;
        cur_end = em;
    endtask

    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(8'h00, 1'b1, 1'b1);
        send_frame(cur_start, cur_end, 32'hFFFF_FFFF, FLAW_NONE, 1'b1, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b1);

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    HOLD_PHASE:  write_markers(8'h00, 8'hFF);
                    DRAIN_PHASE: write_markers(8'hFF, 8'h00);
                    QUIET_PHASE: write_markers(8'hA5, 8'hA5);
                    default:     write_markers(crfd_pkg::byte_t'($urandom_range(255)),
                                               crfd_pkg::byte_t'($urandom_range(255)));
                endcase
            end
            quiet <= (p == QUIET_PHASE);
            if (p == HOLD_PHASE)
                hold_reqs <= hold_reqs + 1;
            if (p == DRAIN_PHASE)
            begin
                run_batches(PHASE_ITEMS / 2);
                settle();
                run_batches(PHASE_ITEMS / 2);
            end
            else
                run_batches(PHASE_ITEMS);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d bytes under %0d marker settings, with a long output hold and a drain.",
                 words_sent, PHASES);
        $display("Checked %0d frames and %0d batches without one; %0d mismatches.",
                 frames_found, batches_missed, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/crfd_pkg.sv
rtl/core/crfd_window.sv
rtl/core/crfd_out_buf.sv
rtl/core/card_reply_frame_deframer_unit.sv
dv/crfd_tb_pkg.sv
dv/crfd_frame_checker.sv
dv/tb_top.sv
